[rtl/assert_macros.svh]
// concurrent assertion helpers, sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`define ASSERT_IMPLIES(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`define ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/ffba_pkg.sv]
`default_nettype none

package ffba_pkg;

  localparam int MAX_BLOCKS   = 256;
  localparam int HEADER_BYTES = 8;
  localparam int GAP_BYTES    = 4;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int DW    = 32;
  localparam int ENT_W = DW + 1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic CFG_HEAP_START = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic          hit;
    logic [DW-1:0] next_off;
  } ffba_match_t;

endpackage

`default_nettype wire

[rtl/ffba_match.sv]
`default_nettype none

module ffba_match (
  input  logic                  req_type_i,
  input  logic [ffba_pkg::DW-1:0] req_size_i,
  input  logic [ffba_pkg::DW-1:0] req_addr_i,
  input  logic [ffba_pkg::DW-1:0] heap_start_i,
  input  logic [ffba_pkg::DW-1:0] off_i,
  input  logic [ffba_pkg::DW-1:0] len_i,
  input  logic                  taken_i,
  output ffba_pkg::ffba_match_t   match_o
);
  import ffba_pkg::*;

  logic [DW-1:0] payload;

  assign payload = heap_start_i + off_i + DW'(HEADER_BYTES);

  always_comb begin
    match_o.next_off = off_i + len_i + DW'(HEADER_BYTES + GAP_BYTES);
    if (req_type_i == REQ_FREE) begin
      match_o.hit = taken_i && (payload == req_addr_i);
    end else begin
      match_o.hit = !taken_i && (len_i >= req_size_i);
    end
  end

endmodule

`default_nettype wire

[rtl/first_fit_block_allocator_unit.sv]
`default_nettype none
// channel   | dir | tdata (low bit up)               | tuser
// s_axis    | in  | req_size[31:0], req_addr[63:32]  | req_type
// m_axis    | out | payload_addr[31:0], bytes_in_use[63:32] | status[1:0]
// cfg       | in  | cfg_idx_i 0 heap_start, 1 heap_limit, cfg_wdata_i
// a request walks the block table from entry 0 and stops at the first hit; a walk over all
// blocks with no hit goes on to the tail, as does a request on an empty table; the walk reads
// up to MAX_BLOCKS entries, one entry per cycle from the block table memory
// a zero-size allocate skips the walk; only one request is in flight at a time
// the result waits in an output register; a stalled m_axis holds the next result
// reset clears the block count, tail offset, used count and registers; no clearing pass

module first_fit_block_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // req_size, req_addr
  input  logic        s_axis_tuser_i,   // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // payload_addr, bytes_in_use
  output logic [1:0]  m_axis_tuser_o    // status
);
  import ffba_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q, state_d;

  logic [DW-1:0] heap_start_q, heap_limit_q;
  logic [CNT_W-1:0] total_q, total_d;
  logic [DW-1:0] tail_q, tail_d;
  logic [DW-1:0] used_q, used_d;

  logic          type_q;
  logic [DW-1:0] size_q, addr_q;

  logic [CNT_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;
  logic             chk_vld_q, chk_vld_d;
  logic [DW-1:0]    off_q, off_d;

  logic [DW-1:0] res_addr_q, res_addr_d;
  logic [1:0]    res_st_q, res_st_d;

  logic          out_vld_q;
  logic [DW-1:0] out_addr_q, out_used_q;
  logic [1:0]    out_st_q;

  logic [ENT_W-1:0] mem [MAX_BLOCKS];
  logic [ENT_W-1:0] rd_q;
  logic             rd_en;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;

  logic        accept;
  logic        last_chk;
  logic        full;
  logic [DW+1:0] reach;
  ffba_match_t match;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);

  ffba_match u_match (
    .req_type_i  (type_q),
    .req_size_i  (size_q),
    .req_addr_i  (addr_q),
    .heap_start_i(heap_start_q),
    .off_i       (off_q),
    .len_i       (rd_q[DW-1:0]),
    .taken_i     (rd_q[DW]),
    .match_o     (match)
  );

  assign last_chk = (CNT_W'(chk_idx_q) + CNT_W'(1)) == total_q;
  assign reach    = {2'b00, heap_start_q} + {2'b00, tail_q} + {2'b00, size_q}
                  + (DW+2)'(HEADER_BYTES);
  assign full     = (total_q >= CNT_W'(MAX_BLOCKS)) || (reach >= {2'b00, heap_limit_q});
  assign rd_en    = (state_q == S_WALK) && (idx_q < total_q);

  always_comb begin
    state_d    = state_q;
    total_d    = total_q;
    tail_d     = tail_q;
    used_d     = used_q;
    idx_d      = idx_q;
    chk_idx_d  = chk_idx_q;
    chk_vld_d  = 1'b0;
    off_d      = off_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    mem_we     = 1'b0;
    mem_waddr  = chk_idx_q;
    mem_wdata  = rd_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d = '0;
          off_d = '0;
          if (s_axis_tuser_i == REQ_ALLOC && s_axis_tdata_i[31:0] == '0) begin
            res_addr_d = '0;
            res_st_d   = ST_ZERO;
            state_d    = S_OUT;
          end else if (total_q == '0) begin
            state_d = S_TAIL;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (rd_en) begin
          idx_d     = idx_q + CNT_W'(1);
          chk_idx_d = idx_q[IDX_W-1:0];
          chk_vld_d = 1'b1;
        end
        if (chk_vld_q) begin
          if (match.hit) begin
            mem_we    = 1'b1;
            chk_vld_d = 1'b0;
            state_d   = S_OUT;
            res_st_d  = ST_OK;
            if (type_q == REQ_FREE) begin
              mem_wdata  = {1'b0, rd_q[DW-1:0]};
              used_d     = used_q - (rd_q[DW-1:0] + DW'(HEADER_BYTES));
              res_addr_d = '0;
            end else begin
              mem_wdata  = {1'b1, rd_q[DW-1:0]};
              used_d     = used_q + size_q + DW'(HEADER_BYTES);
              res_addr_d = heap_start_q + off_q + DW'(HEADER_BYTES);
            end
          end else begin
            off_d = match.next_off;
            if (last_chk) begin
              chk_vld_d = 1'b0;
              state_d   = S_TAIL;
            end
          end
        end
      end
      S_TAIL: begin
        state_d    = S_OUT;
        res_addr_d = '0;
        if (type_q == REQ_FREE) begin
          res_st_d = ST_UNKNOWN;
        end else if (full) begin
          res_st_d = ST_FULL;
        end else begin
          res_st_d   = ST_OK;
          mem_we     = 1'b1;
          mem_waddr  = total_q[IDX_W-1:0];
          mem_wdata  = {1'b1, size_q};
          total_d    = total_q + CNT_W'(1);
          tail_d     = tail_q + size_q + DW'(HEADER_BYTES + GAP_BYTES);
          used_d     = used_q + size_q + DW'(HEADER_BYTES + GAP_BYTES);
          res_addr_d = heap_start_q + tail_q + DW'(HEADER_BYTES);
        end
      end
      S_OUT: begin
        if (!out_vld_q || m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= mem[idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      heap_start_q <= '0;
      heap_limit_q <= '0;
      total_q      <= '0;
      tail_q       <= '0;
      used_q       <= '0;
      chk_vld_q    <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      tail_q    <= tail_d;
      used_q    <= used_d;
      chk_vld_q <= chk_vld_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEAP_START) begin
          heap_start_q <= cfg_wdata_i;
        end else begin
          heap_limit_q <= cfg_wdata_i;
        end
      end
      if (state_q == S_OUT && (!out_vld_q || m_axis_tready_i)) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    chk_idx_q  <= chk_idx_d;
    off_q      <= off_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    if (accept) begin
      type_q <= s_axis_tuser_i;
      size_q <= s_axis_tdata_i[31:0];
      addr_q <= s_axis_tdata_i[63:32];
    end
    if (state_q == S_OUT && (!out_vld_q || m_axis_tready_i)) begin
      out_addr_q <= res_addr_q;
      out_st_q   <= res_st_q;
      out_used_q <= used_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_used_q, out_addr_q};
  assign m_axis_tuser_o  = out_st_q;

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_total_bound, total_q <= CNT_W'(MAX_BLOCKS), "block count past table size")
  `ASSERT_IMPLIES(a_we_state, mem_we, state_q == S_WALK || state_q == S_TAIL, "stray table write")
  `ASSERT_IMPLIES(a_chk_walk, chk_vld_q, state_q == S_WALK, "entry check outside walk")
  `ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "request accepted but block idle")

endmodule

`default_nettype wire
